// ===== rtl/fgc_pkg.sv =====
// Shared types, constants and class codes for the float group compressor.
package fgc_pkg;

   localparam int GROUP_SIZE  = 8;
   localparam int VALUE_W     = 32;
   localparam int LANE_IDX_W  = $clog2(GROUP_SIZE);
   localparam int BYTES_W     = 3;
   localparam int CODE_W      = 2;
   localparam int BITMAP_W    = CODE_W * GROUP_SIZE;
   localparam int REQ_DATA_W  = VALUE_W * GROUP_SIZE;
   localparam int RSP_DATA_W  = 40;

   // lane class codes as they appear in the bitmap
   localparam logic [CODE_W-1:0] CODE_ZERO = 2'd0;
   localparam logic [CODE_W-1:0] CODE_8    = 2'd1;
   localparam logic [CODE_W-1:0] CODE_16   = 2'd2;
   localparam logic [CODE_W-1:0] CODE_RAW  = 2'd3;

   // byte counts per word kind
   localparam logic [BYTES_W-1:0] BYTES_NONE   = 3'd0;
   localparam logic [BYTES_W-1:0] BYTES_8      = 3'd1;
   localparam logic [BYTES_W-1:0] BYTES_16     = 3'd2;
   localparam logic [BYTES_W-1:0] BYTES_RAW    = 3'd4;
   localparam logic [BYTES_W-1:0] BYTES_BITMAP = 3'd2;

   // magnitude thresholds on the sign-stripped bit pattern
   localparam logic [30:0] MAG_INF     = 31'h7F80_0000;
   localparam logic [30:0] MAG_2EXP_15 = 31'h3800_0000;
   localparam logic [30:0] MAG_2EXP_7  = 31'h3C00_0000;
   localparam logic [30:0] MAG_ONE     = 31'h3F80_0000;
   localparam logic [7:0]  EXP_BIAS    = 8'd127;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] word;
      logic [BYTES_W-1:0] nbytes;
   } lane_result_type;

   typedef struct packed {
      lane_result_type [GROUP_SIZE-1:0] lane;
      logic                             final_group;
   } group_type;

endpackage

// ===== rtl/fgc_lane.sv =====
// One compression lane: classes a float32 and forms its payload word.
module fgc_lane
   import fgc_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   output lane_result_type    result
);

   logic [30:0] mag;
   logic        sign;
   logic [7:0]  expo;
   logic [3:0]  shamt;
   logic [23:0] mant;
   logic [39:0] ext;
   logic [23:0] quot;
   logic        guard;
   logic        sticky;
   logic [23:0] quot_rnd;
   logic [22:0] frac;

   assign mag  = value[30:0];
   assign sign = value[31];
   assign expo = value[30:23];
   assign mant = {1'b1, value[22:0]};

   // 1 + |f| in single precision: align mantissa, round to nearest even
   assign shamt    = 4'(EXP_BIAS - expo);
   assign ext      = {mant, 16'b0} >> shamt;
   assign quot     = ext[39:16];
   assign guard    = ext[15];
   assign sticky   = |ext[14:0];
   assign quot_rnd = quot + {23'b0, guard & (sticky | quot[0])};
   assign frac     = quot_rnd[22:0];

   // class by magnitude, NaN and infinity stay raw
   always_comb begin
      result.word   = value;
      result.nbytes = BYTES_RAW;
      result.code   = CODE_RAW;
      priority if (mag > MAG_INF) begin
         result.code = CODE_RAW;
      end else if (mag < MAG_2EXP_15) begin
         result.code   = CODE_ZERO;
         result.nbytes = BYTES_NONE;
         result.word   = '0;
      end else if (mag < MAG_2EXP_7) begin
         result.code   = CODE_16;
         result.nbytes = BYTES_16;
         result.word   = {16'b0, sign, frac[22:8]};
      end else if (mag < MAG_ONE) begin
         result.code   = CODE_8;
         result.nbytes = BYTES_8;
         result.word   = {24'b0, sign, frac[22:16]};
      end else begin
         result.code = CODE_RAW;
      end
   end

endmodule

// ===== rtl/fgc_merge.sv =====
// Merge stage: holds one group of lane results and sends bitmap then payloads.
module fgc_merge
   import fgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  grp_valid,
   output logic                  grp_ready,
   input  group_type             grp,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   group_type                 b_grp_ff, b_grp_in;
   logic                      map_pend_ff, map_pend_in;
   logic [GROUP_SIZE-1:0]     pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic                      busy;
   logic                      advance;
   logic                      emit;
   logic                      last_word;
   logic                      done;
   logic                      load;
   logic [LANE_IDX_W-1:0]     pick;
   logic [GROUP_SIZE-1:0]     pick_mask;
   logic [BITMAP_W-1:0]       bitmap;
   logic [VALUE_W-1:0]        sel_word;
   logic [BYTES_W-1:0]        sel_bytes;

   assign busy    = map_pend_ff | (|pend_ff);
   assign advance = !rsp_valid_ff || rsp_tready;
   assign emit    = busy && advance;

   // lowest pending lane goes next
   always_comb begin
      pick = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
         if (pend_ff[j]) begin
            pick = LANE_IDX_W'(j);
         end
      end
      pick_mask = GROUP_SIZE'(1) << pick;
   end

   // bitmap of class codes, lane j at bits 2j+1..2j
   always_comb begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
         bitmap[CODE_W*j +: CODE_W] = b_grp_ff.lane[j].code;
      end
   end

   // word selection for this beat
   always_comb begin
      if (map_pend_ff) begin
         sel_word  = {{(VALUE_W-BITMAP_W){1'b0}}, bitmap};
         sel_bytes = BYTES_BITMAP;
         last_word = (pend_ff == '0);
      end else begin
         sel_word  = b_grp_ff.lane[pick].word;
         sel_bytes = b_grp_ff.lane[pick].nbytes;
         last_word = ((pend_ff & ~pick_mask) == '0);
      end
   end

   assign done      = emit && last_word;
   assign grp_ready = !busy || done;
   assign load      = grp_valid && grp_ready;

   // group buffer and pending flags
   always_comb begin
      b_grp_in    = b_grp_ff;
      map_pend_in = map_pend_ff;
      pend_in     = pend_ff;
      if (emit) begin
         if (map_pend_ff) begin
            map_pend_in = 1'b0;
         end else begin
            pend_in = pend_ff & ~pick_mask;
         end
      end
      if (load) begin
         b_grp_in    = grp;
         map_pend_in = 1'b1;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            pend_in[j] = (grp.lane[j].code != CODE_ZERO);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W-VALUE_W-BYTES_W){1'b0}}, sel_bytes, sel_word};
         rsp_last_in  = last_word;
         rsp_user_in  = last_word & b_grp_ff.final_group;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_pend_ff  <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_pend_ff  <= map_pend_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_grp_ff    <= b_grp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a freshly loaded group always starts with its bitmap
   a_load_bitmap: assert property (@(posedge clock) disable iff (reset)
      load |=> map_pend_ff)
      else $error("group loaded without bitmap pending");

   // stream end only on a group's last word
   a_user_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_last_ff)
      else $error("stream end outside group end");

   // payload beats retire exactly one pending lane
   a_pend_count: assert property (@(posedge clock) disable iff (reset)
      emit && !map_pend_ff && !load |=>
         $countones(pend_ff) == $countones($past(pend_ff)) - 1)
      else $error("pending lane count off");

   // byte count on the port is always legal
   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[VALUE_W +: BYTES_W] == BYTES_8 ||
                        rsp_data_ff[VALUE_W +: BYTES_W] == BYTES_16 ||
                        rsp_data_ff[VALUE_W +: BYTES_W] == BYTES_RAW))
      else $error("bad byte count");

endmodule

// ===== rtl/float_group_compressor_core.sv =====
// Top level of the float group compressor: eight lanes, group register, merge.
//
//  channel | dir | beat                                  | ends with
//  req_    | in  | one group of eight float32 values      | req_tlast = final group
//  rsp_    | out | bitmap or one payload word            | rsp_tlast = group end
//
//  A group gives its bitmap plus one payload word per nonzero lane, so 1 to
//  9 output words; the merge stage sends one output word per cycle unless
//  rsp_tready stalls it. Lanes work in parallel in the cycle of acceptance.
//  A group register sits in front of the merge buffer, so the next group
//  is taken while the current one is still sent. Reset is synchronous and
//  clears all valid and pending flags. A stall on rsp_tready holds the
//  output beat and, once the buffers are full, drops req_tready.
module float_group_compressor_core
   import fgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value_0 .. value_7, 32 bits each
   input  logic                  req_tlast,  // final_group
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_word[31:0], out_bytes[34:32], zero
   output logic                  rsp_tlast,  // group_end
   output logic                  rsp_tuser   // stream_end
);

   lane_result_type [GROUP_SIZE-1:0] lane_res;
   group_type                        a_grp_ff, a_grp_in;
   logic                             a_valid_ff, a_valid_in;
   logic                             grp_ready;
   logic                             req_accept;

   // parallel lanes
   for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_lane
      fgc_lane u_lane (
         .value  (req_tdata[VALUE_W*j +: VALUE_W]),
         .result (lane_res[j])
      );
   end

   // group register between lanes and merge
   assign req_tready = !a_valid_ff || grp_ready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      a_grp_in.lane        = lane_res;
      a_grp_in.final_group = req_tlast;
      a_valid_in           = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (grp_ready) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_grp_ff <= a_grp_in;
      end
   end

   // bitmap and payload sequencing
   fgc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (a_valid_ff),
      .grp_ready  (grp_ready),
      .grp        (a_grp_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for float_group_compressor_core: random and directed groups.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fgc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_GROUPS  = 213;
   localparam int TAIL_CYCLES    = 40;

   // one expected output beat
   typedef struct {
      logic [VALUE_W-1:0] word;
      logic [BYTES_W-1:0] nbytes;
      logic               group_end;
      logic               stream_end;
   } word_beat_type;

   // Predicts the compressed word stream and checks the beats leaving the block
   class compressed_stream_model;
      word_beat_type pending_words[$];
      int unsigned   mismatches;

      function logic [CODE_W-1:0] lane_code(logic [VALUE_W-1:0] x);
         logic [30:0] mag;
         mag = x[30:0];
         if (mag > MAG_INF) return CODE_RAW;       // NaN
         if (mag < MAG_2EXP_15) return CODE_ZERO;
         if (mag < MAG_2EXP_7) return CODE_16;
         if (mag < MAG_ONE) return CODE_8;
         return CODE_RAW;                          // >= 1 and infinity
      endfunction

      // fraction of float(|f| + 1): |f| * 2^23 rounded to nearest even, mod 2^23
      function logic [22:0] sum_fraction(logic [VALUE_W-1:0] x);
         int unsigned shift, mant, q, rem, half;
         shift = 127 - int'(x[30:23]);
         mant  = {8'd0, 1'b1, x[22:0]};
         q     = mant >> shift;
         rem   = mant & ((32'd1 << shift) - 1);
         half  = 32'd1 << (shift - 1);
         if (rem > half || (rem == half && (q & 1) != 0)) q++;
         return q[22:0];
      endfunction

      function void note_group(logic [REQ_DATA_W-1:0] values, logic final_group);
         word_beat_type       beat;
         word_beat_type       group_words[$];
         logic [BITMAP_W-1:0] bitmap;
         logic [CODE_W-1:0]   code;
         logic [VALUE_W-1:0]  x;
         logic [22:0]         frac;
         bitmap = '0;
         for (int j = 0; j < GROUP_SIZE; j++)
            bitmap[CODE_W*j +: CODE_W] = lane_code(values[VALUE_W*j +: VALUE_W]);
         beat.word       = {16'd0, bitmap};
         beat.nbytes     = BYTES_BITMAP;
         beat.group_end  = 1'b0;
         beat.stream_end = 1'b0;
         group_words.push_back(beat);
         // payloads in lane order, nothing for zero lanes
         for (int j = 0; j < GROUP_SIZE; j++) begin
            x    = values[VALUE_W*j +: VALUE_W];
            code = bitmap[CODE_W*j +: CODE_W];
            frac = sum_fraction(x);
            if (code == CODE_16) begin
               beat.word   = {16'd0, x[31], frac[22:8]};
               beat.nbytes = BYTES_16;
               group_words.push_back(beat);
            end else if (code == CODE_8) begin
               beat.word   = {24'd0, x[31], frac[22:16]};
               beat.nbytes = BYTES_8;
               group_words.push_back(beat);
            end else if (code == CODE_RAW) begin
               beat.word   = x;
               beat.nbytes = BYTES_RAW;
               group_words.push_back(beat);
            end
         end
         group_words[group_words.size()-1].group_end  = 1'b1;
         group_words[group_words.size()-1].stream_end = final_group;
         foreach (group_words[k]) pending_words.push_back(group_words[k]);
      endfunction

      function void compare_field(string field, logic [VALUE_W-1:0] exp_val,
                                  logic [VALUE_W-1:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field,
                     exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] data, logic last, logic user);
         word_beat_type exp_beat;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual %h last %b user %b",
                     $time, data, last, user);
            mismatches++;
            return;
         end
         exp_beat = pending_words.pop_front();
         compare_field("out_word", exp_beat.word, data[31:0]);
         compare_field("out_bytes", 32'(exp_beat.nbytes), 32'(data[34:32]));
         compare_field("padding", 32'd0, 32'(data[RSP_DATA_W-1:35]));
         compare_field("group_end", 32'(exp_beat.group_end), 32'(last));
         compare_field("stream_end", 32'(exp_beat.stream_end), 32'(user));
      endfunction

      function int outstanding();
         return pending_words.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   compressed_stream_model comp_model = new();

   bit quiet_phase     = 1'b0;  // no idling on either side
   bit rsp_hold_request = 1'b0;
   int sender_idle_pct = 20;
   int idle_cycles     = 0;

   float_group_compressor_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // note accepted groups, check accepted words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) comp_model.note_group(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) comp_model.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("float_group_compressor_core test failed");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet_phase || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // offer one group and hold it until accepted
   task automatic send_group(input logic [REQ_DATA_W-1:0] values, input logic final_group);
      req_tvalid <= 1'b1;
      req_tdata  <= values;
      req_tlast  <= final_group;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      if (!quiet_phase && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_lanes(input logic [31:0] l0, l1, l2, l3, l4, l5, l6, l7,
                             input logic final_group);
      send_group({l7, l6, l5, l4, l3, l2, l1, l0}, final_group);
      sender_gap();
   endtask

   // wait until every expected word has come out
   task automatic drain();
      @(posedge clock);
      while (comp_model.outstanding() != 0) @(posedge clock);
   endtask

   // one lane biased toward class boundaries and rounding cases
   function automatic logic [31:0] random_lane();
      logic        sign;
      logic [7:0]  expo;
      logic [22:0] mant;
      int unsigned pick, shift;
      sign = 1'($urandom_range(0, 1));
      mant = 23'($urandom);
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
         expo = 8'($urandom_range(0, 111));       // zero class, subnormals too
      end else if (pick <= 3) begin
         expo = 8'($urandom_range(112, 119));     // 16-bit class
      end else if (pick <= 5) begin
         expo = 8'($urandom_range(120, 126));     // 8-bit class
      end else if (pick == 6) begin
         expo = 8'($urandom_range(127, 254));     // raw normal
      end else if (pick == 7) begin
         // exact tie on the rounding bit
         expo  = 8'($urandom_range(112, 126));
         shift = 127 - expo;
         mant  = (mant & ~((23'd1 << shift) - 23'd1)) | (23'd1 << (shift - 1));
      end else if (pick == 8) begin
         // infinity, NaN, just below one, zero, class edges
         case ($urandom_range(0, 5))
            0: {expo, mant} = {8'hFF, 23'd0};
            1: expo = 8'hFF;
            2: {expo, mant} = {8'd126, 23'h7FFFFF};
            3: {expo, mant} = {8'd0, 23'd0};
            4: {expo, mant} = {8'(16 + 8 * $urandom_range(12, 14) - 8), 23'd0};
            default: {expo, mant} = {8'(111 + 8 * $urandom_range(0, 1)), 23'h7FFFFF};
         endcase
      end else begin
         return $urandom;
      end
      return {sign, expo, mant};
   endfunction

   initial begin
      logic [REQ_DATA_W-1:0] values;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zeros, class edges, rounding ties, specials
      send_lanes(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_lanes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_lanes(32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h37FF_FFFF,
                 32'hB7FF_FFFF, 32'h007F_FFFF, 32'h8000_0001, 32'h3000_0000, 1'b0);
      send_lanes(32'h3800_0000, 32'hB800_0000, 32'h3BFF_FFFF, 32'hBBFF_FFFF,
                 32'h3800_4000, 32'h3800_C000, 32'h3A12_3456, 32'hBB7F_FFFF, 1'b0);
      send_lanes(32'h3C00_0000, 32'hBC00_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                 32'h3F7F_FFFD, 32'h3F00_0000, 32'h3E80_0001, 32'hBDCC_CCCD, 1'b0);
      send_lanes(32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 1'b1);
      send_lanes(32'h0000_0000, 32'h3800_0000, 32'h3C00_0000, 32'h3F80_0000,
                 32'h8000_0000, 32'hB800_0001, 32'hBC00_0001, 32'hC049_0FDB, 1'b0);
      // a single raw lane at each position
      for (int j = 0; j < GROUP_SIZE; j++) begin
         values = '0;
         values[VALUE_W*j +: VALUE_W] = 32'hC000_0000 | j;
         send_group(values, j == GROUP_SIZE - 1);
         sender_gap();
      end
      send_lanes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_lanes(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);

      // sender pause until the block is empty
      req_tvalid <= 1'b0;
      drain();

      // random groups
      for (int i = 0; i < RANDOM_GROUPS; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(0, 2))
               0: sender_idle_pct = 0;
               1: sender_idle_pct = 15;
               default: sender_idle_pct = 40;
            endcase
         end
         if (i == 60) rsp_hold_request = 1'b1;
         if (i == 190) quiet_phase = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            for (int j = 0; j < REQ_DATA_W / 32; j++) values[32*j +: 32] = $urandom;
         end else begin
            for (int j = 0; j < GROUP_SIZE; j++) values[VALUE_W*j +: VALUE_W] = random_lane();
         end
         send_group(values, $urandom_range(0, 5) == 0);
         if (i == 120) begin
            req_tvalid <= 1'b0;
            drain();
         end else begin
            sender_gap();
         end
      end
      req_tvalid <= 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (comp_model.mismatches == 0 && comp_model.outstanding() == 0) begin
         $display("float_group_compressor_core test passed");
      end else begin
         $display("float_group_compressor_core test failed");
      end
      $finish;
   end

endmodule
